>>> design/assembly_source_tokenizer_core_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSEMBLY_SOURCE_TOKENIZER_CORE_MACROS_SVH
`define ASSEMBLY_SOURCE_TOKENIZER_CORE_MACROS_SVH

// Implication checked on every rising clk edge, off while rst is high.
`define AST_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Signal that must hold its value across a stalled cycle.
`define AST_ASSERT_HOLD(label, cond, sig, msg) \
  label: assert property (@(posedge clk) disable iff (rst) \
    (cond) |=> $stable(sig)) else $error(msg);

`endif

>>> design/ast_pkg.sv
`timescale 1ns / 1ps
package ast_pkg;

  localparam int POS_W          = 24;
  localparam int MAX_REC        = 6;
  localparam int MAX_CHAR_CHARS = 8;
  localparam int REC_IDX_W      = $clog2(MAX_REC + 1);

  typedef logic [POS_W-1:0] pos_t;
  localparam pos_t POS_MAX = {POS_W{1'b1}};

  localparam logic [3:0] KW_FAIL   = 4'd15;
  localparam logic [4:0] COUNT_SAT = 5'd31;

  // token kinds
  localparam logic [5:0] K_EOF = 6'd0, K_NEWLINE = 6'd1, K_COMMENT = 6'd2, K_DOC = 6'd3;
  localparam logic [5:0] K_IDENT = 6'd4, K_LABELDEF = 6'd5, K_LOCAL = 6'd6;
  localparam logic [5:0] K_LOCALDEF = 6'd7, K_RREF = 6'd8, K_RDEF = 6'd9, K_RUP = 6'd10;
  localparam logic [5:0] K_RDOWN = 6'd11, K_INT = 6'd12, K_FLOAT = 6'd13, K_STRING = 6'd14;
  localparam logic [5:0] K_CHAR = 6'd15, K_DOLLAR = 6'd16, K_PLUS = 6'd17, K_MINUS = 6'd18;
  localparam logic [5:0] K_TILDE = 6'd19, K_CARET = 6'd20, K_LPAREN = 6'd21;
  localparam logic [5:0] K_RPAREN = 6'd22, K_COMMA = 6'd23, K_AMP = 6'd24;
  localparam logic [5:0] K_AMPAMP = 6'd25, K_PIPE = 6'd26, K_PIPEPIPE = 6'd27;
  localparam logic [5:0] K_EQEQ = 6'd28, K_BANG = 6'd29, K_BANGEQ = 6'd30, K_LT = 6'd31;
  localparam logic [5:0] K_LTLT = 6'd32, K_LTEQ = 6'd33, K_GT = 6'd34, K_GTGT = 6'd35;
  localparam logic [5:0] K_GTEQ = 6'd36, K_STAR = 6'd37, K_STARSTAR = 6'd38;
  localparam logic [5:0] K_SLASH = 6'd39, K_PERCENT = 6'd40, K_PERPER = 6'd41;
  localparam logic [5:0] K_DOTDOT = 6'd42, K_ERROR = 6'd43;

  // diagnostic codes
  localparam logic [5:0] D_ESC_INCOMPLETE = 6'd0, D_ESC_UNKNOWN = 6'd1, D_STR_OPEN = 6'd2;
  localparam logic [5:0] D_CHAR_OPEN = 6'd3, D_CHAR_EMPTY = 6'd4, D_CHAR_LONG = 6'd5;
  localparam logic [5:0] D_CHAR_NONASCII = 6'd6, D_UNEXPECTED = 6'd7;

  // lexer modes
  localparam logic [4:0] M_IDLE = 5'd0, M_CMT1 = 5'd1, M_CMT = 5'd2, M_IDENT = 5'd3;
  localparam logic [4:0] M_IDENT_DOT = 5'd4, M_DOT = 5'd5, M_LOCAL = 5'd6, M_REUSE = 5'd7;
  localparam logic [4:0] M_NUM0 = 5'd8, M_DEC = 5'd9, M_DEC_DOT = 5'd10, M_FRAC = 5'd11;
  localparam logic [4:0] M_HEX = 5'd12, M_BIN = 5'd13, M_OCT = 5'd14, M_STR = 5'd15;
  localparam logic [4:0] M_STR_ESC = 5'd16, M_CHAR = 5'd17, M_CHAR_ESC = 5'd18;
  localparam logic [4:0] M_OP = 5'd19;

  typedef struct packed {
    logic [4:0] mode;
    logic [7:0] la0;
    logic [1:0] la_cnt;
    pos_t       pos;
    pos_t       tstart;
    pos_t       estart;
    logic [4:0] lcount;
    logic       nonascii;
    logic       doc;
    logic       raw;
    logic [3:0] kw;
  } st_t;

  typedef struct packed {
    logic       diag;
    logic [5:0] kind;
    pos_t       s;
    pos_t       e;
  } rec_t;

  typedef struct packed {
    st_t                      st;
    rec_t [MAX_REC-1:0]       recs;
    logic [REC_IDX_W-1:0]     n;
  } work_t;

  function automatic st_t st_reset();
    st_t s;
    s = '0;
    s.mode = M_IDLE;
    return s;
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic id_start(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic logic id_body(logic [7:0] c);
    return id_start(c) || is_digit(c);
  endfunction

  function automatic logic is_hex(logic [7:0] c);
    return is_digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
  endfunction

  function automatic logic [3:0] kw_next(logic [3:0] s, logic [7:0] c);
    logic [7:0] want;
    logic       ok;
    ok = 1'b1;
    case (s)
      4'd1:    want = "n";
      4'd2:    want = "c";
      4'd3:    want = "l";
      4'd4:    want = "u";
      4'd5:    want = "d";
      4'd6:    want = "e";
      4'd8:    want = "i";
      4'd9:    want = "l";
      4'd10:   want = "e";
      default: begin
        want = 8'h00;
        ok   = 1'b0;
      end
    endcase
    return (ok && c == want) ? s + 4'd1 : KW_FAIL;
  endfunction

  function automatic work_t push(work_t w, logic d, logic [5:0] code, pos_t s, pos_t e);
    if (w.n < REC_IDX_W'(MAX_REC)) begin
      w.recs[w.n[REC_IDX_W-1:0]] = '{diag: d, kind: code, s: s, e: e};
      w.n = w.n + 1'b1;
    end
    return w;
  endfunction

  function automatic work_t emit(work_t w, logic [5:0] kind, pos_t s, pos_t e);
    w = push(w, 1'b0, kind, s, e);
    w.st.raw = (kind == K_IDENT) && (w.st.kw == 4'd7 || w.st.kw == 4'd11);
    return w;
  endfunction

  function automatic work_t diag(work_t w, logic [5:0] code, pos_t s, pos_t e);
    return push(w, 1'b1, code, s, e);
  endfunction

  function automatic work_t add_chars(work_t w, logic [1:0] n);
    logic [5:0] sum;
    sum = {1'b0, w.st.lcount} + 6'(n);
    w.st.lcount = (sum > 6'(COUNT_SAT)) ? COUNT_SAT : sum[4:0];
    return w;
  endfunction

  function automatic work_t escape_byte(work_t w, logic [7:0] c, pos_t nx, logic in_char);
    logic known;
    known = c == "0" || c == "t" || c == "n" || c == 8'h27 || c == 8'h22 || c == 8'h5c;
    if (known) begin
      if (in_char) w = add_chars(w, 2'd1);
    end else begin
      w = diag(w, D_ESC_UNKNOWN, w.st.estart, nx);
      if (in_char) begin
        w = add_chars(w, 2'd2);
        if (c[7]) w.st.nonascii = 1'b1;
      end
    end
    return w;
  endfunction

  function automatic work_t char_finish(work_t w, logic closed, pos_t e);
    if (!closed) w = diag(w, D_CHAR_OPEN, w.st.tstart, e);
    else if (w.st.lcount == 5'd0) w = diag(w, D_CHAR_EMPTY, w.st.tstart, e);
    else if (w.st.lcount > 5'(MAX_CHAR_CHARS)) w = diag(w, D_CHAR_LONG, w.st.tstart, e);
    if (w.st.nonascii) w = diag(w, D_CHAR_NONASCII, w.st.tstart, e);
    return emit(w, K_CHAR, w.st.tstart, e);
  endfunction

  // Resolves a held operator byte; hit is set when c completes a pair.
  function automatic work_t op_resolve(work_t w, logic [7:0] c, logic have, pos_t p,
                                       pos_t nx, output logic hit);
    logic [5:0] pair;
    logic [5:0] single;
    logic       m;
    pair   = K_ERROR;
    single = K_ERROR;
    m      = 1'b0;
    case (w.st.la0)
      "&": begin single = K_AMP;     m = c == "&"; pair = K_AMPAMP;   end
      "|": begin single = K_PIPE;    m = c == "|"; pair = K_PIPEPIPE; end
      "=": begin single = K_ERROR;   m = c == "="; pair = K_EQEQ;     end
      "!": begin single = K_BANG;    m = c == "="; pair = K_BANGEQ;   end
      "<": begin
        single = K_LT;
        m      = c == "<" || c == "=";
        pair   = (c == "<") ? K_LTLT : K_LTEQ;
      end
      ">": begin
        single = K_GT;
        m      = c == ">" || c == "=";
        pair   = (c == ">") ? K_GTGT : K_GTEQ;
      end
      "*": begin single = K_STAR;    m = c == "*"; pair = K_STARSTAR; end
      "%": begin single = K_PERCENT; m = c == "%"; pair = K_PERPER;   end
      default: ;
    endcase
    w.st.la_cnt = 2'd0;
    w.st.mode   = M_IDLE;
    hit = have && m;
    if (hit) begin
      w = emit(w, pair, w.st.tstart, nx);
    end else begin
      w = emit(w, single, w.st.tstart, p);
      if (single == K_ERROR) w = diag(w, D_UNEXPECTED, w.st.tstart, p);
    end
    return w;
  endfunction

endpackage

>>> design/assembly_source_tokenizer_core.sv
`timescale 1ns / 1ps
// Byte-stream tokenizer for assembly source. Each accepted byte runs through the
// lexer state machine in the cycle it is taken and leaves up to six token or
// diagnostic records in a small record buffer, which the output side drains one
// record per cycle while out_ready is high; last_of_run marks the final record
// of a byte. Bytes yielding at most one record stream at a byte a cycle while
// out_ready is high; a byte yielding several records holds the input until
// they have all left. A new byte is taken in the same cycle the last buffered
// record leaves. The byte flagged end_of_source closes any open token, adds an
// Eof record and returns the offsets to zero for the next source.
module assembly_source_tokenizer_core import ast_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] source_byte,
  input  logic       end_of_source,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       is_diagnostic,
  output logic [5:0] kind_code,
  output pos_t       span_start,
  output pos_t       span_end,
  output logic       last_of_run
);

  st_t                  st;
  work_t                step;
  rec_t [MAX_REC-1:0]   recs;
  logic [REC_IDX_W-1:0] count;
  logic [REC_IDX_W-1:0] idx;
  rec_t                 cur;
  logic                 take_in;
  logic                 take_out;

  ast_lex_step u_step (
    .st            (st),
    .source_byte   (source_byte),
    .end_of_source (end_of_source),
    .result        (step)
  );

  assign out_valid = idx < count;
  assign cur       = recs[idx[REC_IDX_W-1:0]];
  assign take_out  = out_valid && out_ready;
  assign last_of_run = (idx + 1'b1) == count;
  assign in_ready  = !out_valid || (take_out && last_of_run);
  assign take_in   = in_valid && in_ready;

  assign is_diagnostic = cur.diag;
  assign kind_code     = cur.kind;
  assign span_start    = cur.s;
  assign span_end      = cur.e;

  always_ff @(posedge clk) begin
    if (rst) begin
      st    <= st_reset();
      count <= '0;
      idx   <= '0;
    end else if (take_in) begin
      st    <= step.st;
      count <= step.n;
      idx   <= '0;
    end else if (take_out) begin
      idx <= idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take_in) recs <= step.recs;
  end

endmodule

>>> design/ast_lex_step.sv
`timescale 1ns / 1ps
module ast_lex_step import ast_pkg::*; (
  input  st_t        st,
  input  logic [7:0] source_byte,
  input  logic       end_of_source,
  output work_t      result
);

  // One pass of the mode machine; again means the byte is seen once more.
  function automatic work_t lex_pass(work_t w, logic [7:0] c, pos_t p, pos_t nx,
                                     output logic again);
    logic hit;
    again = 1'b0;
    case (w.st.mode)
      M_IDLE: begin
        w.st.tstart = p;
        case (c) inside
          " ", 8'h09, 8'h0d: ;
          8'h0a: w = emit(w, K_NEWLINE, p, nx);
          "#": begin w.st.doc = 1'b0; w.st.mode = M_CMT1; end
          ["a":"z"], ["A":"Z"], "_": begin
            w.st.kw   = (c == "i") ? 4'd1 : ((c == "f") ? 4'd8 : KW_FAIL);
            w.st.mode = M_IDENT;
          end
          ".": w.st.mode = M_DOT;
          "@": w.st.mode = M_REUSE;
          "0": w.st.mode = M_NUM0;
          ["1":"9"]: w.st.mode = M_DEC;
          8'h22: w.st.mode = M_STR;
          8'h27: begin
            w.st.lcount   = 5'd0;
            w.st.nonascii = 1'b0;
            w.st.mode     = M_CHAR;
          end
          "$": w = emit(w, K_DOLLAR, p, nx);
          "+": w = emit(w, K_PLUS, p, nx);
          "-": w = emit(w, K_MINUS, p, nx);
          "~": w = emit(w, K_TILDE, p, nx);
          "^": w = emit(w, K_CARET, p, nx);
          "(": w = emit(w, K_LPAREN, p, nx);
          ")": w = emit(w, K_RPAREN, p, nx);
          ",": w = emit(w, K_COMMA, p, nx);
          "/": w = emit(w, K_SLASH, p, nx);
          "&", "|", "=", "!", "<", ">", "*", "%": begin
            w.st.la0    = c;
            w.st.la_cnt = 2'd1;
            w.st.mode   = M_OP;
          end
          default: begin
            w = emit(w, K_ERROR, p, nx);
            w = diag(w, D_UNEXPECTED, p, nx);
          end
        endcase
      end
      M_CMT1: begin
        w.st.mode = M_CMT;
        if (c == "#") w.st.doc = 1'b1;
        else again = 1'b1;
      end
      M_CMT: begin
        if (c == 8'h0a) begin
          w = emit(w, w.st.doc ? K_DOC : K_COMMENT, w.st.tstart, p);
          w.st.mode = M_IDLE;
          again = 1'b1;
        end
      end
      M_IDENT: begin
        if (id_body(c)) begin
          w.st.kw = kw_next(w.st.kw, c);
        end else if (c == ".") begin
          w.st.estart = p;
          w.st.la0    = ".";
          w.st.la_cnt = 2'd1;
          w.st.mode   = M_IDENT_DOT;
        end else if (c == ":") begin
          w = emit(w, K_LABELDEF, w.st.tstart, nx);
          w.st.mode = M_IDLE;
        end else begin
          w = emit(w, K_IDENT, w.st.tstart, p);
          w.st.mode = M_IDLE;
          again = 1'b1;
        end
      end
      M_IDENT_DOT: begin
        w.st.la_cnt = 2'd0;
        if (id_start(c)) begin
          w.st.kw   = KW_FAIL;
          w.st.mode = M_IDENT;
        end else begin
          w = emit(w, K_IDENT, w.st.tstart, w.st.estart);
          w.st.tstart = w.st.estart;
          w.st.mode   = M_DOT;
          again = 1'b1;
        end
      end
      M_DOT: begin
        if (id_body(c)) begin
          w.st.mode = M_LOCAL;
        end else if (c == ".") begin
          w = emit(w, K_DOTDOT, w.st.tstart, nx);
          w.st.mode = M_IDLE;
        end else begin
          w = emit(w, K_ERROR, w.st.tstart, p);
          w = diag(w, D_UNEXPECTED, w.st.tstart, p);
          w.st.mode = M_IDLE;
          again = 1'b1;
        end
      end
      M_LOCAL: begin
        if (c == ":") begin
          w = emit(w, K_LOCALDEF, w.st.tstart, nx);
          w.st.mode = M_IDLE;
        end else if (!id_body(c)) begin
          w = emit(w, K_LOCAL, w.st.tstart, p);
          w.st.mode = M_IDLE;
          again = 1'b1;
        end
      end
      M_REUSE: begin
        if (c == ":" || c == "+" || c == "-") begin
          w = emit(w, (c == ":") ? K_RDEF : ((c == "+") ? K_RUP : K_RDOWN),
                   w.st.tstart, nx);
          w.st.mode = M_IDLE;
        end else if (!id_body(c)) begin
          w = emit(w, K_RREF, w.st.tstart, p);
          w.st.mode = M_IDLE;
          again = 1'b1;
        end
      end
      M_NUM0: begin
        case (c) inside
          "x", "X": w.st.mode = M_HEX;
          "b", "B": w.st.mode = M_BIN;
          "o", "O": w.st.mode = M_OCT;
          default: begin
            w.st.mode = M_DEC;
            again = 1'b1;
          end
        endcase
      end
      M_DEC: begin
        if (c == ".") begin
          w.st.estart = p;
          w.st.la0    = ".";
          w.st.la_cnt = 2'd1;
          w.st.mode   = M_DEC_DOT;
        end else if (!(is_digit(c) || c == "_")) begin
          w = emit(w, K_INT, w.st.tstart, p);
          w.st.mode = M_IDLE;
          again = 1'b1;
        end
      end
      M_DEC_DOT: begin
        w.st.la_cnt = 2'd0;
        if (is_digit(c)) begin
          w.st.mode = M_FRAC;
        end else begin
          w = emit(w, K_INT, w.st.tstart, w.st.estart);
          w.st.tstart = w.st.estart;
          w.st.mode   = M_DOT;
          again = 1'b1;
        end
      end
      M_FRAC, M_HEX, M_BIN, M_OCT: begin
        logic more;
        more = 1'b0;
        case (w.st.mode)
          M_FRAC:  more = is_digit(c);
          M_HEX:   more = is_hex(c);
          M_BIN:   more = c == "0" || c == "1";
          default: more = c >= "0" && c <= "7";
        endcase
        if (!(more || c == "_")) begin
          w = emit(w, (w.st.mode == M_FRAC) ? K_FLOAT : K_INT, w.st.tstart, p);
          w.st.mode = M_IDLE;
          again = 1'b1;
        end
      end
      M_STR: begin
        if (c == 8'h22) begin
          w = emit(w, K_STRING, w.st.tstart, nx);
          w.st.mode = M_IDLE;
        end else if (c == 8'h0a) begin
          w = diag(w, D_STR_OPEN, w.st.tstart, p);
          w = emit(w, K_STRING, w.st.tstart, p);
          w.st.mode = M_IDLE;
          again = 1'b1;
        end else if (c == 8'h5c && !w.st.raw) begin
          w.st.estart = p;
          w.st.mode   = M_STR_ESC;
        end
      end
      M_STR_ESC, M_CHAR_ESC: begin
        w.st.mode = (w.st.mode == M_STR_ESC) ? M_STR : M_CHAR;
        if (c == 8'h0a) begin
          w = diag(w, D_ESC_INCOMPLETE, w.st.estart, p);
          again = 1'b1;
        end else begin
          w = escape_byte(w, c, nx, w.st.mode == M_CHAR);
        end
      end
      M_CHAR: begin
        if (c == 8'h27) begin
          w = char_finish(w, 1'b1, nx);
          w.st.mode = M_IDLE;
        end else if (c == 8'h0a) begin
          w = char_finish(w, 1'b0, p);
          w.st.mode = M_IDLE;
          again = 1'b1;
        end else if (c == 8'h5c) begin
          w.st.estart = p;
          w.st.mode   = M_CHAR_ESC;
        end else begin
          w = add_chars(w, 2'd1);
          if (c[7]) w.st.nonascii = 1'b1;
        end
      end
      M_OP: begin
        w = op_resolve(w, c, 1'b1, p, nx, hit);
        again = !hit;
      end
      default: begin
        w.st.mode = M_IDLE;
        again = 1'b1;
      end
    endcase
    return w;
  endfunction

  // Closes whatever is open at end of source, then Eof and a fresh state.
  function automatic work_t flush(work_t w, pos_t e);
    logic hit;
    case (w.st.mode)
      M_CMT1, M_CMT: w = emit(w, w.st.doc ? K_DOC : K_COMMENT, w.st.tstart, e);
      M_IDENT:       w = emit(w, K_IDENT, w.st.tstart, e);
      M_IDENT_DOT, M_DEC_DOT: begin
        w = emit(w, (w.st.mode == M_IDENT_DOT) ? K_IDENT : K_INT, w.st.tstart, w.st.estart);
        w = emit(w, K_ERROR, w.st.estart, e);
        w = diag(w, D_UNEXPECTED, w.st.estart, e);
      end
      M_DOT: begin
        w = emit(w, K_ERROR, w.st.tstart, e);
        w = diag(w, D_UNEXPECTED, w.st.tstart, e);
      end
      M_LOCAL:                        w = emit(w, K_LOCAL, w.st.tstart, e);
      M_REUSE:                        w = emit(w, K_RREF, w.st.tstart, e);
      M_NUM0, M_DEC, M_HEX, M_BIN, M_OCT: w = emit(w, K_INT, w.st.tstart, e);
      M_FRAC:                         w = emit(w, K_FLOAT, w.st.tstart, e);
      M_STR, M_STR_ESC: begin
        if (w.st.mode == M_STR_ESC) w = diag(w, D_ESC_INCOMPLETE, w.st.estart, e);
        w = diag(w, D_STR_OPEN, w.st.tstart, e);
        w = emit(w, K_STRING, w.st.tstart, e);
      end
      M_CHAR, M_CHAR_ESC: begin
        if (w.st.mode == M_CHAR_ESC) w = diag(w, D_ESC_INCOMPLETE, w.st.estart, e);
        w = char_finish(w, 1'b0, e);
      end
      M_OP:    w = op_resolve(w, 8'h00, 1'b0, e, e, hit);
      default: ;
    endcase
    w = emit(w, K_EOF, e, e);
    w.st = st_reset();
    return w;
  endfunction

  pos_t  p;
  pos_t  nx;
  logic  again;
  work_t w;

  assign p  = st.pos;
  assign nx = (p == POS_MAX) ? POS_MAX : p + 1'b1;

  // at most three passes: a pending dot, a fallback mode, then idle
  always_comb begin
    w      = '0;
    w.st   = st;
    again  = 1'b1;
    for (int i = 0; i < 3; i++) begin
      if (again) w = lex_pass(w, source_byte, p, nx, again);
    end
    w.st.pos = nx;
    if (end_of_source) w = flush(w, nx);
    result = w;
  end

endmodule

>>> design/ast_checker.sv
`timescale 1ns / 1ps
`include "assembly_source_tokenizer_core_macros.svh"
module ast_checker import ast_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       is_diagnostic,
  input logic [5:0] kind_code,
  input pos_t       span_end,
  input logic       last_of_run
);

  logic eof_rec;

  assign eof_rec = out_valid && !is_diagnostic && kind_code == K_EOF;

  `AST_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "record dropped while stalled")
  `AST_ASSERT_HOLD(a_span_hold, out_valid && !out_ready, span_end, "span moved while stalled")
  // no new byte may enter while a record is blocked downstream
  `AST_ASSERT(a_no_in_on_stall, out_valid && !out_ready |-> !in_ready, "input taken on stall")
  `AST_ASSERT(a_eof_last, eof_rec |-> last_of_run, "Eof not last")

endmodule

bind assembly_source_tokenizer_core ast_checker u_ast_checker (
  .clk           (clk),
  .rst           (rst),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .is_diagnostic (is_diagnostic),
  .kind_code     (kind_code),
  .span_end      (span_end),
  .last_of_run   (last_of_run)
);

>>> test/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import ast_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int DRAIN_WAIT  = 30;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] source_byte = 8'h00;
  logic       end_of_source = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       is_diagnostic;
  logic [5:0] kind_code;
  pos_t       span_start;
  pos_t       span_end;
  logic       last_of_run;

  assembly_source_tokenizer_core i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .source_byte(source_byte), .end_of_source(end_of_source),
    .out_valid(out_valid), .out_ready(out_ready),
    .is_diagnostic(is_diagnostic), .kind_code(kind_code),
    .span_start(span_start), .span_end(span_end), .last_of_run(last_of_run)
  );

  // one source byte request; chk rows carry a hand-written final record
  typedef struct {
    logic [7:0] b;
    bit         eos;
    bit         chk;
    bit         cd;
    logic [5:0] ck;
    pos_t       cs;
    pos_t       ce;
  } req_t;

  typedef struct {
    bit         d;
    logic [5:0] k;
    pos_t       s;
    pos_t       e;
    bit         l;
  } token_rec_t;

  req_t       req_q[$];
  token_rec_t run_q[$];
  token_rec_t token_q[$];
  int         n_err = 0;
  int         cycle = 0;
  int         req_idx = 0;

  // lexer state of the predictor
  logic [4:0] lx_mode;
  logic [7:0] lx_la;
  pos_t       lx_pos, lx_tstart, lx_estart;
  int         lx_cnt;
  bit         lx_na, lx_doc, lx_raw;
  logic [3:0] lx_kw;

  function automatic bit c_dig(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction
  function automatic bit c_start(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction
  function automatic bit c_body(logic [7:0] c);
    return c_start(c) || c_dig(c);
  endfunction
  function automatic bit c_hex(logic [7:0] c);
    return c_dig(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
  endfunction

  function automatic logic [3:0] kw_step(logic [3:0] s, logic [7:0] c);
    string inc, fil;
    inc = "include";
    fil = "file";
    if (s >= 1 && s <= 6) return (c == inc[s]) ? s + 4'd1 : KW_FAIL;
    if (s >= 8 && s <= 10) return (c == fil[s-7]) ? s + 4'd1 : KW_FAIL;
    return KW_FAIL;
  endfunction

  function automatic void lex_reset();
    lx_mode = M_IDLE; lx_la = 8'h00; lx_pos = '0; lx_tstart = '0; lx_estart = '0;
    lx_cnt = 0; lx_na = 0; lx_doc = 0; lx_raw = 0; lx_kw = 4'd0;
  endfunction

  function automatic void rec_add(bit d, logic [5:0] k, pos_t s, pos_t e);
    if (run_q.size() < MAX_REC) run_q.insert(run_q.size(), token_rec_t'{d, k, s, e, 1'b0});
  endfunction
  function automatic void tok(logic [5:0] k, pos_t s, pos_t e);
    rec_add(1'b0, k, s, e);
    lx_raw = (k == K_IDENT) && (lx_kw == 4'd7 || lx_kw == 4'd11);
  endfunction
  function automatic void note(logic [5:0] k, pos_t s, pos_t e);
    rec_add(1'b1, k, s, e);
  endfunction

  function automatic void bump_chars(int n);
    lx_cnt = lx_cnt + n;
    if (lx_cnt > COUNT_SAT) lx_cnt = COUNT_SAT;
  endfunction

  function automatic void esc_byte(logic [7:0] c, pos_t nx, bit in_char);
    if (c == "0" || c == "t" || c == "n" || c == 8'h27 || c == 8'h22 || c == 8'h5c) begin
      if (in_char) bump_chars(1);
    end else begin
      note(D_ESC_UNKNOWN, lx_estart, nx);
      if (in_char) begin
        bump_chars(2);
        if (c[7]) lx_na = 1;
      end
    end
  endfunction

  function automatic void close_char(bit closed, pos_t e);
    if (!closed) note(D_CHAR_OPEN, lx_tstart, e);
    else if (lx_cnt == 0) note(D_CHAR_EMPTY, lx_tstart, e);
    else if (lx_cnt > MAX_CHAR_CHARS) note(D_CHAR_LONG, lx_tstart, e);
    if (lx_na) note(D_CHAR_NONASCII, lx_tstart, e);
    tok(K_CHAR, lx_tstart, e);
  endfunction

  // held operator byte: returns 1 when c completes a two-byte operator
  function automatic bit resolve_op(logic [7:0] c, bit have, pos_t p, pos_t nx);
    logic [5:0] pr, sg;
    bit         m;
    pr = K_ERROR; sg = K_ERROR; m = 0;
    case (lx_la)
      "&": begin sg = K_AMP;     m = c == "&"; pr = K_AMPAMP;   end
      "|": begin sg = K_PIPE;    m = c == "|"; pr = K_PIPEPIPE; end
      "=": begin sg = K_ERROR;   m = c == "="; pr = K_EQEQ;     end
      "!": begin sg = K_BANG;    m = c == "="; pr = K_BANGEQ;   end
      "<": begin sg = K_LT; m = c == "<" || c == "="; pr = (c == "<") ? K_LTLT : K_LTEQ; end
      ">": begin sg = K_GT; m = c == ">" || c == "="; pr = (c == ">") ? K_GTGT : K_GTEQ; end
      "*": begin sg = K_STAR;    m = c == "*"; pr = K_STARSTAR; end
      "%": begin sg = K_PERCENT; m = c == "%"; pr = K_PERPER;   end
      default: ;
    endcase
    lx_mode = M_IDLE;
    if (have && m) begin
      tok(pr, lx_tstart, nx);
      return 1;
    end
    tok(sg, lx_tstart, p);
    if (sg == K_ERROR) note(D_UNEXPECTED, lx_tstart, p);
    return 0;
  endfunction

  function automatic void lex_idle(logic [7:0] c, pos_t p, pos_t nx);
    lx_tstart = p;
    if (c == " " || c == 8'h09 || c == 8'h0d) return;
    if (c == 8'h0a) tok(K_NEWLINE, p, nx);
    else if (c == "#") begin lx_doc = 0; lx_mode = M_CMT1; end
    else if (c_start(c)) begin
      lx_kw = (c == "i") ? 4'd1 : ((c == "f") ? 4'd8 : KW_FAIL);
      lx_mode = M_IDENT;
    end
    else if (c == ".") lx_mode = M_DOT;
    else if (c == "@") lx_mode = M_REUSE;
    else if (c_dig(c)) lx_mode = (c == "0") ? M_NUM0 : M_DEC;
    else if (c == 8'h22) lx_mode = M_STR;
    else if (c == 8'h27) begin lx_cnt = 0; lx_na = 0; lx_mode = M_CHAR; end
    else begin
      case (c)
        "$": tok(K_DOLLAR, p, nx);
        "+": tok(K_PLUS, p, nx);
        "-": tok(K_MINUS, p, nx);
        "~": tok(K_TILDE, p, nx);
        "^": tok(K_CARET, p, nx);
        "(": tok(K_LPAREN, p, nx);
        ")": tok(K_RPAREN, p, nx);
        ",": tok(K_COMMA, p, nx);
        "/": tok(K_SLASH, p, nx);
        "&", "|", "=", "!", "<", ">", "*", "%": begin
          lx_la = c;
          lx_mode = M_OP;
        end
        default: begin
          tok(K_ERROR, p, nx);
          note(D_UNEXPECTED, p, nx);
        end
      endcase
    end
  endfunction

  // act: 0 byte consumed, 1 token closed and byte retried from idle, 2 retry in new mode
  function automatic void lex_byte(logic [7:0] c, pos_t p, pos_t nx);
    int act;
    do begin
      act = 0;
      case (lx_mode)
        M_IDLE: lex_idle(c, p, nx);
        M_CMT1: begin
          lx_mode = M_CMT;
          if (c == "#") lx_doc = 1;
          else act = 2;
        end
        M_CMT: if (c == 8'h0a) begin
          tok(lx_doc ? K_DOC : K_COMMENT, lx_tstart, p);
          act = 1;
        end
        M_IDENT: begin
          if (c_body(c)) lx_kw = kw_step(lx_kw, c);
          else if (c == ".") begin lx_estart = p; lx_la = "."; lx_mode = M_IDENT_DOT; end
          else if (c == ":") begin tok(K_LABELDEF, lx_tstart, nx); lx_mode = M_IDLE; end
          else begin tok(K_IDENT, lx_tstart, p); act = 1; end
        end
        M_IDENT_DOT: begin
          if (c_start(c)) begin lx_kw = KW_FAIL; lx_mode = M_IDENT; end
          else begin
            tok(K_IDENT, lx_tstart, lx_estart);
            lx_tstart = lx_estart;
            lx_mode = M_DOT;
            act = 2;
          end
        end
        M_DOT: begin
          if (c_body(c)) lx_mode = M_LOCAL;
          else if (c == ".") begin tok(K_DOTDOT, lx_tstart, nx); lx_mode = M_IDLE; end
          else begin
            tok(K_ERROR, lx_tstart, p);
            note(D_UNEXPECTED, lx_tstart, p);
            act = 1;
          end
        end
        M_LOCAL: begin
          if (c == ":") begin tok(K_LOCALDEF, lx_tstart, nx); lx_mode = M_IDLE; end
          else if (!c_body(c)) begin tok(K_LOCAL, lx_tstart, p); act = 1; end
        end
        M_REUSE: begin
          if (c == ":" || c == "+" || c == "-") begin
            tok(c == ":" ? K_RDEF : (c == "+" ? K_RUP : K_RDOWN), lx_tstart, nx);
            lx_mode = M_IDLE;
          end else if (!c_body(c)) begin
            tok(K_RREF, lx_tstart, p);
            act = 1;
          end
        end
        M_NUM0: begin
          if (c == "x" || c == "X") lx_mode = M_HEX;
          else if (c == "b" || c == "B") lx_mode = M_BIN;
          else if (c == "o" || c == "O") lx_mode = M_OCT;
          else begin lx_mode = M_DEC; act = 2; end
        end
        M_DEC: begin
          if (c == ".") begin lx_estart = p; lx_la = "."; lx_mode = M_DEC_DOT; end
          else if (!(c_dig(c) || c == "_")) begin tok(K_INT, lx_tstart, p); act = 1; end
        end
        M_DEC_DOT: begin
          if (c_dig(c)) lx_mode = M_FRAC;
          else begin
            tok(K_INT, lx_tstart, lx_estart);
            lx_tstart = lx_estart;
            lx_mode = M_DOT;
            act = 2;
          end
        end
        M_FRAC: if (!(c_dig(c) || c == "_")) begin tok(K_FLOAT, lx_tstart, p); act = 1; end
        M_HEX: if (!(c_hex(c) || c == "_")) begin tok(K_INT, lx_tstart, p); act = 1; end
        M_BIN: if (!(c == "0" || c == "1" || c == "_")) begin
          tok(K_INT, lx_tstart, p);
          act = 1;
        end
        M_OCT: if (!((c >= "0" && c <= "7") || c == "_")) begin
          tok(K_INT, lx_tstart, p);
          act = 1;
        end
        M_STR: begin
          if (c == 8'h22) begin tok(K_STRING, lx_tstart, nx); lx_mode = M_IDLE; end
          else if (c == 8'h0a) begin
            note(D_STR_OPEN, lx_tstart, p);
            tok(K_STRING, lx_tstart, p);
            act = 1;
          end else if (c == 8'h5c && !lx_raw) begin
            lx_estart = p;
            lx_mode = M_STR_ESC;
          end
        end
        M_STR_ESC: begin
          lx_mode = M_STR;
          if (c == 8'h0a) begin note(D_ESC_INCOMPLETE, lx_estart, p); act = 2; end
          else esc_byte(c, nx, 0);
        end
        M_CHAR: begin
          if (c == 8'h27) begin close_char(1, nx); lx_mode = M_IDLE; end
          else if (c == 8'h0a) begin close_char(0, p); act = 1; end
          else if (c == 8'h5c) begin lx_estart = p; lx_mode = M_CHAR_ESC; end
          else begin
            bump_chars(1);
            if (c[7]) lx_na = 1;
          end
        end
        M_CHAR_ESC: begin
          lx_mode = M_CHAR;
          if (c == 8'h0a) begin note(D_ESC_INCOMPLETE, lx_estart, p); act = 2; end
          else esc_byte(c, nx, 1);
        end
        M_OP: if (!resolve_op(c, 1, p, nx)) act = 2;
        default: act = 1;
      endcase
      if (act == 1) lx_mode = M_IDLE;
    end while (act != 0);
  endfunction

  function automatic void lex_flush(pos_t e);
    bit unused;
    case (lx_mode)
      M_CMT1, M_CMT: tok(lx_doc ? K_DOC : K_COMMENT, lx_tstart, e);
      M_IDENT: tok(K_IDENT, lx_tstart, e);
      M_IDENT_DOT, M_DEC_DOT: begin
        tok(lx_mode == M_IDENT_DOT ? K_IDENT : K_INT, lx_tstart, lx_estart);
        tok(K_ERROR, lx_estart, e);
        note(D_UNEXPECTED, lx_estart, e);
      end
      M_DOT: begin tok(K_ERROR, lx_tstart, e); note(D_UNEXPECTED, lx_tstart, e); end
      M_LOCAL: tok(K_LOCAL, lx_tstart, e);
      M_REUSE: tok(K_RREF, lx_tstart, e);
      M_NUM0, M_DEC, M_HEX, M_BIN, M_OCT: tok(K_INT, lx_tstart, e);
      M_FRAC: tok(K_FLOAT, lx_tstart, e);
      M_STR, M_STR_ESC: begin
        if (lx_mode == M_STR_ESC) note(D_ESC_INCOMPLETE, lx_estart, e);
        note(D_STR_OPEN, lx_tstart, e);
        tok(K_STRING, lx_tstart, e);
      end
      M_CHAR, M_CHAR_ESC: begin
        if (lx_mode == M_CHAR_ESC) note(D_ESC_INCOMPLETE, lx_estart, e);
        close_char(0, e);
      end
      M_OP: unused = resolve_op(8'h00, 0, e, e);
      default: ;
    endcase
    tok(K_EOF, e, e);
  endfunction

  function automatic void predict_tokens(req_t r);
    pos_t p, nx;
    p = lx_pos;
    nx = (p == POS_MAX) ? p : p + 1'b1;
    run_q.delete();
    lex_byte(r.b, p, nx);
    lx_pos = nx;
    if (r.eos) begin
      lex_flush(nx);
      lex_reset();
    end
    if (run_q.size() > 0) begin
      run_q[$].l = 1;
      if (r.chk) begin
        run_q[$].d = r.cd; run_q[$].k = r.ck; run_q[$].s = r.cs; run_q[$].e = r.ce;
      end
    end
    foreach (run_q[i]) token_q.insert(token_q.size(), run_q[i]);
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle, what, got, want);
    n_err++;
  endtask

  // ---------------- stimulus building ----------------
  function automatic void add_b(logic [7:0] b);
    req_q.insert(req_q.size(), req_t'{b, 1'b0, 1'b0, 1'b0, 6'd0, '0, '0});
  endfunction
  function automatic void add_s(string s);
    for (int i = 0; i < s.len(); i++) add_b(s[i]);
  endfunction
  function automatic void add_chk(logic [7:0] b, bit eos, bit d, logic [5:0] k, int s, int e);
    req_q.insert(req_q.size(), req_t'{b, eos, 1'b1, d, k, pos_t'(s), pos_t'(e)});
  endfunction
  function automatic void end_src();
    req_q[$].eos = 1'b1;
  endfunction

  function automatic logic [7:0] pick(string set);
    return set[$urandom_range(0, set.len() - 1)];
  endfunction

  function automatic void add_name(int n);
    add_b(pick("abcdefilnuxzQ_"));
    for (int i = 1; i < n; i++) add_b(pick("abcefilnu_Z09"));
  endfunction

  function automatic void gen_fragment();
    int n;
    n = $urandom_range(1, 6);
    case ($urandom_range(0, 13))
      0: add_name(n);
      1: begin
        if ($urandom_range(0, 1)) add_s("include");
        else add_s("file");
        add_s(" \"p\\a\"");
      end
      2: begin
        add_name(n); add_b(".");
        case ($urandom_range(0, 2))
          0: add_name(2);
          1: add_b("9");
          default: add_b(" ");
        endcase
      end
      3: begin add_name(n); add_b(":"); end
      4: begin
        add_b(".");
        case ($urandom_range(0, 3))
          0: add_name(n);
          1: begin add_name(n); add_b(":"); end
          2: add_b(".");
          default: add_b(" ");
        endcase
      end
      5: begin add_b("@"); add_name(n); add_b(pick(":+- ")); end
      6: begin
        case ($urandom_range(0, 5))
          0: begin add_s("0x"); repeat (n) add_b(pick("09afAF_g")); end
          1: begin add_s("0b"); repeat (n) add_b(pick("01_2")); end
          2: begin add_s("0o"); repeat (n) add_b(pick("07_8")); end
          3: repeat (n) add_b(pick("0123456789_"));
          4: begin add_b(pick("123")); add_b("."); repeat (n) add_b(pick("0459_")); end
          default: begin add_b(pick("057")); add_b("."); add_b(pick(". a")); end
        endcase
      end
      7: begin
        add_b(8'h22);
        repeat ($urandom_range(0, 6)) begin
          if ($urandom_range(0, 3) == 0) begin add_b(8'h5c); add_b(pick("0tn\"\\qx'")); end
          else add_b(pick("ab #'c"));
        end
        if ($urandom_range(0, 4) != 0) add_b(8'h22);
        else if ($urandom_range(0, 1)) add_b(8'h5c);
      end
      8: begin
        add_b(8'h27);
        repeat ($urandom_range(0, 11)) begin
          case ($urandom_range(0, 4))
            0: begin add_b(8'h5c); add_b(pick("0tn'\"\\q")); end
            1: add_b(8'($urandom_range(128, 255)));
            default: add_b(pick("ab9 \""));
          endcase
        end
        if ($urandom_range(0, 4) != 0) add_b(8'h27);
        else if ($urandom_range(0, 1)) add_b(8'h5c);
      end
      9: begin
        add_b("#");
        if ($urandom_range(0, 1)) add_b("#");
        repeat (n) add_b(pick("ab \"'\\"));
        add_b(8'h0a);
      end
      10: begin add_b(pick("&|=!<>*%")); if ($urandom_range(0, 1)) add_b(pick("&|=<>*%")); end
      11: add_b(pick("$+-~^(),/"));
      default: add_b(8'($urandom_range(0, 255)));
    endcase
  endfunction

  initial begin
    int nfrag;
    // extremes, lone '=', short eos
    add_chk(8'h00, 0, 1, D_UNEXPECTED, 0, 1);
    add_chk(8'hFF, 0, 1, D_UNEXPECTED, 1, 2);
    add_b("=");
    add_chk(" ", 0, 1, D_UNEXPECTED, 2, 3);
    add_chk("a", 1, 0, K_EOF, 5, 5);
    add_s("''"); end_src();
    add_s("'\\"); end_src();
    add_s("\"\\q\\"); add_b(8'h0a);
    add_s("<=&!"); end_src();
    add_s("x.1"); end_src();
    add_s("'123456789'"); end_src();
    add_s("##d"); end_src();
    // random sources
    while (req_q.size() < 150) begin
      nfrag = $urandom_range(1, 10);
      for (int i = 0; i < nfrag; i++) begin
        gen_fragment();
        if (i < nfrag - 1 || $urandom_range(0, 1))
          case ($urandom_range(0, 4))
            0: ;
            1: add_b(8'h0a);
            2: add_b(8'h09);
            default: add_b(" ");
          endcase
      end
      end_src();
    end
  end

  // ---------------- clock, reset, driving, checking ----------------
  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    lex_reset();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
  end

  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  int burst_left = 0;
  int gap_left = 0;
  int rmode = 0;
  logic [7:0] rpat = 8'hA5;

  always @(posedge clk) begin : drive_check
    token_rec_t w;
    bit         nv;
    if (!rst) begin
      // input side
      nv = in_valid;
      if (in_valid && in_ready) begin
        predict_tokens(req_q[req_idx]);
        req_idx++;
        nv = 0;
      end
      if (!nv && req_idx < req_q.size()) begin
        if (gap_left > 0) gap_left--;
        else begin
          nv = 1;
          source_byte <= req_q[req_idx].b;
          end_of_source <= req_q[req_idx].eos;
          if (burst_left > 0) burst_left--;
          else begin
            burst_left = $urandom_range(1, 20);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
          end
        end
      end
      in_valid <= nv;

      // output side
      if (out_valid && out_ready) begin
        if (token_q.size() == 0) begin
          report("unexpected record", 1, 0);
        end else begin
          w = token_q.pop_front();
          if (is_diagnostic !== w.d) report("is_diagnostic", is_diagnostic, w.d);
          if (kind_code !== w.k) report("kind_code", kind_code, w.k);
          if (span_start !== w.s) report("span_start", span_start, w.s);
          if (span_end !== w.e) report("span_end", span_end, w.e);
          if (last_of_run !== w.l) report("last_of_run", last_of_run, w.l);
        end
      end
      if (cycle % 50 == 0) rmode = $urandom_range(0, 3);
      rpat = {rpat[6:0], rpat[7]};
      case (rmode)
        0: out_ready <= 1'b1;
        1: out_ready <= $urandom_range(0, 1);
        2: out_ready <= rpat[0];
        default: out_ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  initial begin
    @(negedge rst);
    while (req_q.size() == 0 || req_idx < req_q.size() || token_q.size() != 0)
      @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (n_err == 0 && token_q.size() == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
